// ===== sv/eat_pkg.sv =====
// Package for the eased animation timer table.
// Word types, action and result codes, and the controller/datapath interface.
// No dependencies.
`timescale 1ns / 1ps

package eat_pkg;

  // Action codes of the input word
  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_STEP = 2'd1,
    ACT_GET  = 2'd2,
    ACT_NONE = 2'd3
  } act_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] entry_id;
    logic [31:0] tick_ms;
    logic [15:0] duration;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  slot;
    logic [4:0]  active_count;
    logic [16:0] progress;
    logic        finished;
  } out_word_t;

  // One table entry as held in memory
  typedef struct packed {
    logic [15:0] id;
    logic [31:0] start;
    logic [15:0] dur;
    logic        flag;
  } ent_t;

  localparam logic [16:0] ONE_FX = 17'h10000;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CMP, S_MOVE, S_DIV, S_MUL0, S_MUL1, S_MUL2, S_RES
  } state_t;

  // Kind of result word to build
  typedef enum logic [2:0] {
    RES_NONE, RES_ADD_OK, RES_FAIL, RES_STEP, RES_GET_MISS, RES_GET_DONE, RES_GET_EASED
  } res_kind_t;

  typedef enum logic [1:0] {
    MUL_SQ, MUL_LO, MUL_HI
  } mul_phase_t;

  typedef struct packed {
    logic       load_item;
    logic       idx_inc;
    logic       rd_idx;
    logic       rd_last;
    logic       wr_cur;
    logic       wr_append;
    logic       wr_move;
    logic       div_start;
    logic       div_step;
    logic       mul_en;
    mul_phase_t mul_phase;
    logic       res_load;
    res_kind_t  res_kind;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic idx_end;
    logic full;
    logic id_match;
    logic step_done;
    logic complete;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/eat_ctrl.sv =====
// Controller for the eased animation timer table.
// Sequences search, removal, division and cube steps; uses eat_pkg.
`timescale 1ns / 1ps

module eat_ctrl
  import eat_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t    state, state_next;
  res_kind_t kind, kind_next;

  // State and pending result kind
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= RES_NONE;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    kind_next    = kind;
    cmd          = '0;
    cmd.res_kind = kind;
    in_ready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_RD;
        end
      end
      S_RD: begin
        if (sts.act == ACT_NONE) begin
          kind_next  = RES_NONE;
          state_next = S_RES;
        end else if (sts.idx_end) begin
          state_next = S_RES;
          unique case (sts.act)
            ACT_ADD: begin
              if (!sts.full) begin
                cmd.wr_append = 1'b1;
                kind_next     = RES_ADD_OK;
              end else begin
                kind_next = RES_FAIL;
              end
            end
            ACT_STEP: kind_next = RES_STEP;
            ACT_GET:  kind_next = RES_GET_MISS;
            default:  kind_next = RES_NONE;
          endcase
        end else begin
          cmd.rd_idx = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.act == ACT_STEP) begin
          if (sts.step_done) begin
            cmd.rd_last = 1'b1;
            state_next  = S_MOVE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_RD;
          end
        end else if (sts.id_match) begin
          if (sts.act == ACT_ADD) begin
            cmd.wr_cur = 1'b1;
            kind_next  = RES_ADD_OK;
            state_next = S_RES;
          end else if (sts.complete) begin
            kind_next  = RES_GET_DONE;
            state_next = S_RES;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_RD;
        end
      end
      S_MOVE: begin
        // last entry fills the freed slot, which is checked again
        cmd.wr_move = 1'b1;
        state_next  = S_RD;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = MUL_SQ;
        state_next    = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = MUL_LO;
        state_next    = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = MUL_HI;
        kind_next     = RES_GET_EASED;
        state_next    = S_RES;
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== sv/eat_dp.sv =====
// Datapath for the eased animation timer table.
// Entry memory, count, divider, cube multiplier and output register; uses eat_pkg.
`timescale 1ns / 1ps

module eat_dp
  import eat_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
)(
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_data,
  input  logic      cfg_valid,
  input  logic      cfg_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  cmd_t      cmd,
  output sts_t      sts
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  in_word_t        item;
  logic            reduced;
  logic [CW-1:0]   count;
  logic [CW-1:0]   idx;
  ent_t            mem [MAX_ENTRIES];
  ent_t            rd_q;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  ent_t            wr_data;
  logic [IW-1:0]   rd_addr;
  logic [CW-1:0]   last;
  logic [31:0]     elapsed;
  logic            complete;
  logic [15:0]     rem;
  logic [16:0]     rem2;
  logic [15:0]     quo;
  logic [3:0]      div_cnt;
  logic [16:0]     inv;
  logic [16:0]     mul_a;
  logic [33:0]     prod;
  logic [33:0]     sq, plo, phi;
  logic [50:0]     cube;
  logic [16:0]     eased;
  logic [CW+3:0]   slot_ext;
  logic [CW+4:0]   cnt_ext;
  out_word_t       res;

  // Input word and configuration
  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) reduced <= 1'b0;
    else if (cfg_valid) reduced <= cfg_data;
  end

  // Scan index and live count
  always_ff @(posedge clk) begin
    if (cmd.load_item) idx <= '0;
    else if (cmd.idx_inc) idx <= idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (cmd.wr_append) count <= count + 1'b1;
    else if (cmd.wr_move) count <= count - 1'b1;
  end

  assign last = count - 1'b1;

  // Memory write port selection
  always_comb begin
    wr_en   = cmd.wr_append | cmd.wr_cur | cmd.wr_move;
    wr_addr = cmd.wr_append ? count[IW-1:0] : idx[IW-1:0];
    if (cmd.wr_move) begin
      wr_data = rd_q;
    end else begin
      wr_data.id    = item.entry_id;
      wr_data.start = item.tick_ms;
      wr_data.dur   = item.duration;
      wr_data.flag  = 1'b0;
    end
    rd_addr = cmd.rd_last ? last[IW-1:0] : idx[IW-1:0];
  end

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_idx || cmd.rd_last) rd_q <= mem[rd_addr];
  end

  // Completion test on the entry just read
  assign elapsed  = item.tick_ms - rd_q.start;
  assign complete = reduced || (rd_q.dur == 16'd0) || (elapsed >= {16'd0, rd_q.dur});

  // Restoring divider: (elapsed << 16) / dur, elapsed below dur
  assign rem2 = {rem, 1'b0};
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem     <= elapsed[15:0];
      quo     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      if (rem2 >= {1'b0, rd_q.dur}) begin
        rem <= 16'(rem2 - {1'b0, rd_q.dur});
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= rem2[15:0];
        quo <= {quo[14:0], 1'b0};
      end
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // Cube of (1.0 - raw) on one 17x17 multiplier, square then low and high halves
  assign inv = ONE_FX - {1'b0, quo};
  always_comb begin
    case (cmd.mul_phase)
      MUL_SQ:  mul_a = inv;
      MUL_LO:  mul_a = sq[16:0];
      default: mul_a = sq[33:17];
    endcase
  end
  assign prod = mul_a * inv;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_phase)
        MUL_SQ:  sq  <= prod;
        MUL_LO:  plo <= prod;
        default: phi <= prod;
      endcase
    end
  end

  assign cube  = {phi, 17'd0} + {17'd0, plo};
  assign eased = ONE_FX - cube[48:32];

  // Result word build
  assign slot_ext = {4'd0, idx};
  assign cnt_ext  = {5'd0, count};
  always_comb begin
    res              = '0;
    res.active_count = cnt_ext[4:0];
    unique case (cmd.res_kind)
      RES_ADD_OK: begin
        res.ok   = 1'b1;
        res.slot = slot_ext[3:0];
      end
      RES_STEP:     res.ok = 1'b1;
      RES_GET_MISS: res.progress = ONE_FX;
      RES_GET_DONE: begin
        res.ok       = 1'b1;
        res.slot     = slot_ext[3:0];
        res.progress = ONE_FX;
        res.finished = ~rd_q.flag;
      end
      RES_GET_EASED: begin
        res.ok       = 1'b1;
        res.slot     = slot_ext[3:0];
        res.progress = eased;
      end
      default: res.ok = 1'b0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.res_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) out_data <= res;
  end

  // Status to controller
  always_comb begin
    sts.act       = act_t'(item.action);
    sts.idx_end   = idx >= count;
    sts.full      = count == CW'(MAX_ENTRIES);
    sts.id_match  = rd_q.id == item.entry_id;
    sts.step_done = complete && !rd_q.flag;
    sts.complete  = complete;
    sts.div_last  = div_cnt == 4'd15;
    sts.out_free  = !out_valid || out_ready;
  end

endmodule

// ===== sv/eased_animation_timer_table.sv =====
// Top level of the eased animation timer table.
// Joins eat_ctrl and eat_dp; uses eat_pkg.
//
// Usage:
//   in_valid/in_ready/in_data carry one action word (add, step or get).
//   out_valid/out_ready/out_data return exactly one result word per action.
//   cfg_valid/cfg_ready/cfg_data write the reduced motion bit; write it only
//   while the block is idle. cfg_ready is always high.
// Flow, with N live entries scanned one at a time from one memory port:
//   add: a scan of the N entries; get: the same up to the match, plus the
//   divider steps and the multiplier steps when progress is partial;
//   step: the scan plus a move for each removed entry. One action is worked
//   at a time; the next is taken once the result is in the output register.
// Reset: the table is empty and reduced motion is off. No clearing pass.
// Stall: a result waits in the output register while out_ready is low; the
//   next action may be accepted, and its result waits until the register
//   frees up.
`timescale 1ns / 1ps

module eased_animation_timer_table
  import eat_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
)(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  eat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  eat_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
